[rtl/core/vn_pkg.sv]
// shared widths and constants of the vector normaliser
package vn_pkg;

  localparam int unsigned COMP_W    = 32;
  localparam int unsigned IN_DATA_W = 3 * COMP_W;
  localparam int unsigned SQ_W      = 2 * COMP_W;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned CFG_W     = 32;

  // 0.001 at the Q32.32 scale of the squared length
  localparam logic [CFG_W-1:0] MIN_SQUARE_RESET = 32'd4294967;

endpackage

[rtl/core/vn_root_step.sv]
// one bit of the quotient search for three lanes, one pipeline stage
module vn_root_step #(
  parameter int unsigned OUT_FRAC_BITS = 16,
  parameter int unsigned BIT           = 0
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [vn_pkg::SUM_W-1:0]               in_sum,
  input  logic                                   in_short,
  input  logic [vn_pkg::SUM_W+2*OUT_FRAC_BITS+1:0] in_rem [3],
  input  logic [vn_pkg::SUM_W+2*OUT_FRAC_BITS+1:0] in_prod [3],
  input  logic [OUT_FRAC_BITS:0]                 in_quo [3],
  input  logic [2:0]                             in_neg,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [vn_pkg::SUM_W-1:0]               out_sum,
  output logic                                   out_short,
  output logic [vn_pkg::SUM_W+2*OUT_FRAC_BITS+1:0] out_rem [3],
  output logic [vn_pkg::SUM_W+2*OUT_FRAC_BITS+1:0] out_prod [3],
  output logic [OUT_FRAC_BITS:0]                 out_quo [3],
  output logic [2:0]                             out_neg
);
  import vn_pkg::*;

  localparam int unsigned W = SUM_W + 2 * OUT_FRAC_BITS + 2;

  logic         valid_r;
  logic [W-1:0] sum_ext;
  logic [W-1:0] trial   [3];
  logic [W:0]   diff    [3];
  logic [W-1:0] rem_nxt [3];
  logic [W-1:0] prod_nxt[3];
  logic [OUT_FRAC_BITS:0] quo_nxt [3];
  logic [SUM_W-1:0] sum_r;
  logic             short_r;
  logic [W-1:0]     rem_r  [3];
  logic [W-1:0]     prod_r [3];
  logic [OUT_FRAC_BITS:0] quo_r [3];
  logic [2:0]       neg_r;

  assign in_ready = !valid_r || out_ready;
  assign sum_ext  = {{(W-SUM_W){1'b0}}, in_sum};

  // try setting this bit: (2*q*2^b + 2^2b) * sum must fit in the remainder
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = (in_prod[i] << (BIT + 1)) + (sum_ext << (2 * BIT));
      diff[i]  = {1'b0, in_rem[i]} - {1'b0, trial[i]};
      if (!diff[i][W]) begin
        rem_nxt[i]  = diff[i][W-1:0];
        prod_nxt[i] = in_prod[i] + (sum_ext << BIT);
        quo_nxt[i]  = in_quo[i] | ((OUT_FRAC_BITS+1)'(1) << BIT);
      end else begin
        rem_nxt[i]  = in_rem[i];
        prod_nxt[i] = in_prod[i];
        quo_nxt[i]  = in_quo[i];
      end
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sum_r   <= in_sum;
      short_r <= in_short;
      neg_r   <= in_neg;
      for (int i = 0; i < 3; i++) begin
        rem_r[i]  <= rem_nxt[i];
        prod_r[i] <= prod_nxt[i];
        quo_r[i]  <= quo_nxt[i];
      end
    end
  end

  assign out_valid = valid_r;
  assign out_sum   = sum_r;
  assign out_short = short_r;
  assign out_rem   = rem_r;
  assign out_prod  = prod_r;
  assign out_quo   = quo_r;
  assign out_neg   = neg_r;

endmodule

[rtl/core/vector3_normalizer.sv]
// vector normaliser top level: magnitudes, squares, sum, bitwise quotient search, output
// registered path: stages 0 to 2, the quotient search steps, then the output register
// one beat per cycle while out_tready is high; one beat per stage, bubbles squeezed out
// the quotient search spends one pipeline stage per result bit, OUT_FRAC_BITS + 1 of them
// stalls ripple back stage by stage, so nothing is dropped or repeated
// synchronous active-low reset empties the pipeline and sets min_square to 0.001 (Q32.32)
module vector3_normalizer #(
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [vn_pkg::CFG_W-1:0]         cfg_wr_data,  // min_square
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [vn_pkg::IN_DATA_W-1:0]     in_tdata,     // vec_x, vec_y, vec_z
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] out_tdata, // norm_x, norm_y, norm_z, pad
  output logic                             out_tuser     // too_short
);
  import vn_pkg::*;

  localparam int unsigned OUT_W  = OUT_FRAC_BITS + 2;
  localparam int unsigned DATA_W = ((3 * OUT_W + 7) / 8) * 8;
  localparam int unsigned PAD_W  = DATA_W - 3 * OUT_W;
  localparam int unsigned W      = SUM_W + 2 * OUT_FRAC_BITS + 2;
  localparam int unsigned NSTEP  = OUT_FRAC_BITS + 1;

  logic [CFG_W-1:0] min_square_r;

  // front stage registers
  logic              v0_r, v1_r, v2_r;
  logic              rdy0, rdy1, rdy2, rdy_out;
  logic [COMP_W-1:0] mag_r [3];
  logic [2:0]        neg0_r, neg1_r, neg2_r;
  logic [SQ_W-1:0]   sq_r  [3];
  logic [SUM_W-1:0]  sum_nxt, sum_r;
  logic              short_nxt, short_r;
  logic [W-1:0]      rem_init_r [3];
  logic [W-1:0]      zero_w [3];
  logic [OUT_FRAC_BITS:0] zero_q [3];

  // search chain links
  logic              c_valid [NSTEP+1];
  logic              c_ready [NSTEP+1];
  logic [SUM_W-1:0]  c_sum   [NSTEP+1];
  logic              c_short [NSTEP+1];
  logic [W-1:0]      c_rem   [NSTEP+1][3];
  logic [W-1:0]      c_prod  [NSTEP+1][3];
  logic [OUT_FRAC_BITS:0] c_quo [NSTEP+1][3];
  logic [2:0]        c_neg   [NSTEP+1];

  // output stage
  logic              out_valid_r;
  logic              out_short_r;
  logic [OUT_W-1:0]  norm_nxt [3];
  logic [OUT_W-1:0]  norm_r   [3];
  logic [OUT_FRAC_BITS:0] qsat;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_square_r <= MIN_SQUARE_RESET;
    end else if (cfg_wr_en) begin
      min_square_r <= cfg_wr_data;
    end
  end

  // stage readiness
  assign rdy_out   = !out_valid_r || out_tready;
  assign rdy2      = !v2_r || c_ready[0];
  assign rdy1      = !v1_r || rdy2;
  assign rdy0      = !v0_r || rdy1;
  assign in_tready = rdy0;

  // front valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_tvalid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // stage 0: sign and magnitude of each component
  always_ff @(posedge clk) begin
    if (rdy0 && in_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        neg0_r[i] <= in_tdata[COMP_W*i + COMP_W-1];
        mag_r[i]  <= in_tdata[COMP_W*i + COMP_W-1]
                   ? (~in_tdata[COMP_W*i +: COMP_W] + COMP_W'(1))
                   : in_tdata[COMP_W*i +: COMP_W];
      end
    end
  end

  // stage 1: squares
  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      neg1_r <= neg0_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SQ_W'(mag_r[i]) * SQ_W'(mag_r[i]);
      end
    end
  end

  // stage 2: sum of squares, threshold test, scaled remainders
  assign sum_nxt   = sq_r[0] + sq_r[1] + sq_r[2];
  assign short_nxt = (sum_nxt == '0) || (sum_nxt < {{(SUM_W-CFG_W){1'b0}}, min_square_r});

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      sum_r   <= sum_nxt;
      short_r <= short_nxt;
      neg2_r  <= neg1_r;
      for (int i = 0; i < 3; i++) begin
        rem_init_r[i] <= {{(W-SQ_W){1'b0}}, sq_r[i]} << (2 * OUT_FRAC_BITS);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      zero_w[i] = '0;
      zero_q[i] = '0;
    end
  end

  assign c_valid[0] = v2_r;
  assign c_sum[0]   = sum_r;
  assign c_short[0] = short_r;
  assign c_rem[0]   = rem_init_r;
  assign c_prod[0]  = zero_w;
  assign c_quo[0]   = zero_q;
  assign c_neg[0]   = neg2_r;
  assign c_ready[NSTEP] = rdy_out;

  // quotient search, most significant bit first
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    vn_root_step #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .BIT           (OUT_FRAC_BITS - k)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_valid[k]),
      .in_ready  (c_ready[k]),
      .in_sum    (c_sum[k]),
      .in_short  (c_short[k]),
      .in_rem    (c_rem[k]),
      .in_prod   (c_prod[k]),
      .in_quo    (c_quo[k]),
      .in_neg    (c_neg[k]),
      .out_valid (c_valid[k+1]),
      .out_ready (c_ready[k+1]),
      .out_sum   (c_sum[k+1]),
      .out_short (c_short[k+1]),
      .out_rem   (c_rem[k+1]),
      .out_prod  (c_prod[k+1]),
      .out_quo   (c_quo[k+1]),
      .out_neg   (c_neg[k+1])
    );
  end

  // clamp to 1.0, apply sign, zero for short vectors
  always_comb begin
    qsat = '0;
    for (int i = 0; i < 3; i++) begin
      qsat = c_quo[NSTEP][i];
      if (qsat > ((OUT_FRAC_BITS+1)'(1) << OUT_FRAC_BITS)) begin
        qsat = (OUT_FRAC_BITS+1)'(1) << OUT_FRAC_BITS;
      end
      if (c_short[NSTEP]) begin
        norm_nxt[i] = '0;
      end else if (c_neg[NSTEP][i]) begin
        norm_nxt[i] = OUT_W'(0) - {1'b0, qsat};
      end else begin
        norm_nxt[i] = {1'b0, qsat};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= c_valid[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && c_valid[NSTEP]) begin
      out_short_r <= c_short[NSTEP];
      norm_r      <= norm_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_short_r;
  assign out_tdata  = {{PAD_W{1'b0}}, norm_r[2], norm_r[1], norm_r[0]};

  // remainder and product words feed only the next step; the last ones are spare
  logic unused_tail;
  assign unused_tail = ^{c_sum[NSTEP], c_rem[NSTEP][0], c_rem[NSTEP][1], c_rem[NSTEP][2],
                         c_prod[NSTEP][0], c_prod[NSTEP][1], c_prod[NSTEP][2]};

endmodule

[rtl/core/vn_checker.sv]
// port checker for the vector normaliser, bound to the top level
module vn_checker #(
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_wr_en,
  input logic [vn_pkg::CFG_W-1:0]         cfg_wr_data,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [vn_pkg::IN_DATA_W-1:0]     in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] out_tdata,
  input logic                             out_tuser
);
  import vn_pkg::*;

  localparam int unsigned OUT_W = OUT_FRAC_BITS + 2;

  logic signed [OUT_W-1:0] nx, ny, nz;
  logic signed [OUT_W-1:0] one_p, one_m;

  assign nx    = out_tdata[OUT_W-1:0];
  assign ny    = out_tdata[2*OUT_W-1:OUT_W];
  assign nz    = out_tdata[3*OUT_W-1:2*OUT_W];
  assign one_p = OUT_W'(1) << OUT_FRAC_BITS;
  assign one_m = -one_p;

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output beat right after reset");

  // a stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output beat changed");

  // short vectors come out as zero
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> nx == '0 && ny == '0 && nz == '0)
    else $error("short vector with nonzero components");

  // components stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> nx <= one_p && nx >= one_m && ny <= one_p && ny >= one_m
                   && nz <= one_p && nz >= one_m)
    else $error("normalised component out of range");

  logic unused_in;
  assign unused_in = ^{cfg_wr_en, cfg_wr_data, in_tvalid, in_tready, in_tdata};

endmodule

bind vector3_normalizer vn_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_vn_checker (.*);
